// ===== hdl/imm_pkg.sv =====
// Shared types and constants for the integer matrix multiplier.
`default_nettype none

package imm_pkg;

  // Widths fixed by the word layout.
  localparam int IDX_W   = 3;
  localparam int DIM_W   = 4;
  localparam int FUNC_W  = 2;
  localparam int ELEM_W  = 64;
  localparam int HALF_W  = 32;
  localparam int ACC_W   = 64;
  localparam int WORD_W  = 72;

  // Input word kinds carried on in_tuser.
  localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_COLS_B    = 2'd1;
  localparam logic [1:0] REG_INNER_LEN = 2'd2;
  localparam logic [1:0] REG_WORD_MODE = 2'd3;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL_LL,
    ST_MUL_LH,
    ST_MUL_HL,
    ST_SUM,
    ST_EMIT
  } state_t;

  // Which pair of 32-bit halves the shared multiplier takes.
  typedef enum logic [1:0] {
    SEL_LL,
    SEL_LH,
    SEL_HL
  } mul_sel_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic     clear;
    logic     mul_en;
    mul_sel_t sel;
  } mac_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/integer_matrix_multiplier_unit.sv =====
// Top level of the integer matrix multiplier: stores, sequencer and result register.
//
//   Channel   Direction  Handshake          Contents
//   in_*      input      tvalid/tready      load A, load B or compute word
//   out_*     output     tvalid/tready      one product element, tlast on the final one
//   cfg_*     input      write enable only  rows_a, cols_b, inner_len, word_mode
//
// A load word is taken whenever the sequencer is idle. A compute word keeps in_tready
// low until its last element is handed off: the one shared 32x32 multiplier forms three
// partial products per term, and each element adds a fetch, a final add and a handoff state.
// A stalled output holds the sequencer in its handoff state. Reset is synchronous;
// the A and B stores are not cleared, so every element must be loaded before use.
`default_nettype none

module integer_matrix_multiplier_unit
  import imm_pkg::*;
#(
  parameter int MAX_DIM    = 8,
  parameter int DATA_WIDTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input words.
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [WORD_W-1:0] in_tdata,   // row_index, col_index, elem_value, zero pad
  input  wire logic [FUNC_W-1:0] in_tuser,   // func
  // Result words.
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [WORD_W-1:0] out_tdata,  // out_row, out_col, product_value, zero pad
  output logic                   out_tlast,
  // Configuration writes.
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [DIM_W-1:0]  cfg_data
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FULL_W = 2 * IDX_W + 1;
  localparam logic [ACC_W-1:0] DMASK = ACC_W'((65'd1 << DATA_WIDTH) - 65'd1);
  localparam logic [ACC_W-1:0] MASK32 = ACC_W'({HALF_W{1'b1}});

  // Configuration registers.
  logic [DIM_W-1:0] rows_a_r;
  logic [DIM_W-1:0] cols_b_r;
  logic [DIM_W-1:0] inner_len_r;
  logic             word_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_W'(1);
      cols_b_r    <= DIM_W'(1);
      inner_len_r <= DIM_W'(1);
      word_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_A:    rows_a_r    <= cfg_data;
        REG_COLS_B:    cols_b_r    <= cfg_data;
        REG_INNER_LEN: inner_len_r <= cfg_data;
        REG_WORD_MODE: word_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Last index of a dimension: zero counts as one, large values saturate.
  function automatic logic [IDX_W-1:0] last_idx(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] e;
    begin
      if (d == '0) begin
        e = DIM_W'(1);
      end else if (d > DIM_W'(MAX_DIM)) begin
        e = DIM_W'(MAX_DIM);
      end else begin
        e = d;
      end
      last_idx = IDX_W'(e - DIM_W'(1));
    end
  endfunction

  function automatic logic [AW-1:0] store_addr(input logic [IDX_W-1:0] row,
                                               input logic [IDX_W-1:0] col);
    logic [FULL_W-1:0] full;
    begin
      full       = FULL_W'(row * FULL_W'(MAX_DIM)) + FULL_W'(col);
      store_addr = AW'(full);
    end
  endfunction

  logic [IDX_W-1:0] m_last;
  logic [IDX_W-1:0] n_last;
  logic [IDX_W-1:0] k_last;

  assign m_last = last_idx(rows_a_r);
  assign n_last = last_idx(cols_b_r);
  assign k_last = last_idx(inner_len_r);

  // Input word fields.
  logic [IDX_W-1:0]  in_row;
  logic [IDX_W-1:0]  in_col;
  logic [ELEM_W-1:0] in_elem;
  logic              in_fire;
  logic              load_ok;
  logic              load_a_en;
  logic              load_b_en;
  logic              start;

  assign in_row  = in_tdata[IDX_W-1:0];
  assign in_col  = in_tdata[2*IDX_W-1:IDX_W];
  assign in_elem = in_tdata[2*IDX_W+ELEM_W-1:2*IDX_W];
  assign in_fire = in_tvalid && in_tready;
  assign load_ok = ({1'b0, in_row} < DIM_W'(MAX_DIM)) && ({1'b0, in_col} < DIM_W'(MAX_DIM));
  assign load_a_en = in_fire && (in_tuser == FUNC_LOAD_A) && load_ok;
  assign load_b_en = in_fire && (in_tuser == FUNC_LOAD_B) && load_ok;
  assign start     = in_fire && (in_tuser == FUNC_COMPUTE);

  // Sequencer state and loop counters.
  state_t           state_r;
  state_t           state_nxt;
  logic [IDX_W-1:0] u_r;
  logic [IDX_W-1:0] u_nxt;
  logic [IDX_W-1:0] v_r;
  logic [IDX_W-1:0] v_nxt;
  logic [IDX_W-1:0] w_r;
  logic [IDX_W-1:0] w_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             slot_free;
  logic             last_elem;
  logic             last_term;

  assign slot_free = !out_valid_r || out_tready;
  assign last_elem = (u_r == m_last) && (v_r == n_last);
  assign last_term = (w_r == k_last);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_FETCH;
      ST_FETCH:  state_nxt = ST_MUL_LL;
      ST_MUL_LL: state_nxt = ST_MUL_LH;
      ST_MUL_LH: state_nxt = ST_MUL_HL;
      ST_MUL_HL: state_nxt = last_term ? ST_SUM : ST_MUL_LL;
      ST_SUM:    state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = last_elem ? ST_IDLE : ST_FETCH;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  mac_ctl_t         mac_ctl;
  logic             rd_en;
  logic             emit;
  logic [IDX_W-1:0] w_sel;

  always_comb begin
    in_tready      = 1'b0;
    rd_en          = 1'b0;
    emit           = 1'b0;
    w_sel          = w_r;
    mac_ctl.clear  = 1'b0;
    mac_ctl.mul_en = 1'b0;
    mac_ctl.sel    = SEL_LL;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_FETCH: begin
        rd_en         = 1'b1;
        mac_ctl.clear = 1'b1;
      end
      ST_MUL_LL: begin
        mac_ctl.mul_en = 1'b1;
        mac_ctl.sel    = SEL_LL;
      end
      ST_MUL_LH: begin
        mac_ctl.mul_en = 1'b1;
        mac_ctl.sel    = SEL_LH;
      end
      ST_MUL_HL: begin
        // The next term is fetched while the last partial product is formed.
        mac_ctl.mul_en = 1'b1;
        mac_ctl.sel    = SEL_HL;
        rd_en          = !last_term;
        w_sel          = w_r + IDX_W'(1);
      end
      ST_SUM:  ;
      ST_EMIT: emit = slot_free;
      default: ;
    endcase
  end

  // Loop counters.
  always_comb begin
    u_nxt = u_r;
    v_nxt = v_r;
    w_nxt = w_r;
    if (start) begin
      u_nxt = '0;
      v_nxt = '0;
      w_nxt = '0;
    end else if ((state_r == ST_MUL_HL) && !last_term) begin
      w_nxt = w_r + IDX_W'(1);
    end else if (emit) begin
      w_nxt = '0;
      if (v_r == n_last) begin
        v_nxt = '0;
        u_nxt = u_r + IDX_W'(1);
      end else begin
        v_nxt = v_r + IDX_W'(1);
      end
    end
  end

  // Result register handshake.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      u_r         <= '0;
      v_r         <= '0;
      w_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      u_r         <= u_nxt;
      v_r         <= v_nxt;
      w_r         <= w_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Element stores, one write and one registered read each.
  logic [DATA_WIDTH-1:0] a_mem [DEPTH];
  logic [DATA_WIDTH-1:0] b_mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_a_r;
  logic [DATA_WIDTH-1:0] rd_b_r;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr_a;
  logic [AW-1:0]         rd_addr_b;

  assign wr_addr   = store_addr(in_row, in_col);
  assign rd_addr_a = store_addr(u_r, w_sel);
  assign rd_addr_b = store_addr(w_sel, v_r);

  always_ff @(posedge clk) begin
    if (load_a_en) begin
      a_mem[wr_addr] <= in_elem[DATA_WIDTH-1:0];
    end
    if (rd_en) begin
      rd_a_r <= a_mem[rd_addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (load_b_en) begin
      b_mem[wr_addr] <= in_elem[DATA_WIDTH-1:0];
    end
    if (rd_en) begin
      rd_b_r <= b_mem[rd_addr_b];
    end
  end

  // Shared multiply-accumulate unit.
  logic [ACC_W-1:0] acc;

  imm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a_op  (ACC_W'(rd_a_r)),
    .b_op  (ACC_W'(rd_b_r)),
    .acc   (acc)
  );

  // Result payload register.
  logic [IDX_W-1:0] out_row_r;
  logic [IDX_W-1:0] out_col_r;
  logic [ACC_W-1:0] out_value_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (emit) begin
      out_row_r   <= u_r;
      out_col_r   <= v_r;
      out_value_r <= acc & (word_mode_r ? DMASK : MASK32);
      out_last_r  <= last_elem;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(WORD_W - 2*IDX_W - ACC_W){1'b0}}, out_value_r, out_col_r, out_row_r};

endmodule

`default_nettype wire

// ===== hdl/imm_mac.sv =====
// Shared 32x32 multiplier with a 64-bit wrapping accumulator.
`default_nettype none

module imm_mac
  import imm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mac_ctl_t         ctl,
  input  wire logic [ACC_W-1:0] a_op,
  input  wire logic [ACC_W-1:0] b_op,
  output logic      [ACC_W-1:0] acc
);

  logic [HALF_W-1:0] mul_x;
  logic [HALF_W-1:0] mul_y;
  logic [ACC_W-1:0]  prod_r;
  logic              add_r;
  logic              add_nxt;
  logic              shift_r;
  logic              shift_nxt;
  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  acc_nxt;
  logic [ACC_W-1:0]  addend;

  // Operand halves for the current partial product.
  always_comb begin
    case (ctl.sel)
      SEL_LL: begin
        mul_x = a_op[HALF_W-1:0];
        mul_y = b_op[HALF_W-1:0];
      end
      SEL_LH: begin
        mul_x = a_op[HALF_W-1:0];
        mul_y = b_op[ACC_W-1:HALF_W];
      end
      SEL_HL: begin
        mul_x = a_op[ACC_W-1:HALF_W];
        mul_y = b_op[HALF_W-1:0];
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  // Cross terms land in the upper half; their upper product bits wrap away.
  assign add_nxt   = ctl.mul_en;
  assign shift_nxt = (ctl.sel != SEL_LL);
  assign addend    = shift_r ? {prod_r[HALF_W-1:0], {HALF_W{1'b0}}} : prod_r;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (add_r) begin
      acc_nxt = acc_r + addend;
    end
  end

  // The product is registered, then added into the accumulator in the following cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_r   <= 1'b0;
      shift_r <= 1'b0;
    end else begin
      add_r   <= add_nxt;
      shift_r <= shift_nxt;
    end
    if (ctl.mul_en) begin
      prod_r <= ACC_W'(mul_x * mul_y);
    end
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

`default_nettype wire
